[rtl/fsfp_pkg.sv]
// Shared types and constants for the flag framed servo command parser.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package fsfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_AW   = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [COUNT_W:0]   MAX_DATA  = 5'd10;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_START_FLAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_FLAG      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_COMMAND = 2'd2;

  localparam logic [BYTE_W-1:0] START_FLAG_RST    = 8'd2;
  localparam logic [BYTE_W-1:0] END_FLAG_RST      = 8'd3;
  localparam logic [BYTE_W-1:0] SERVO_COMMAND_RST = 8'd83;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_ITEM  = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_end;
    logic              is_start;
  } fsfp_word_t;

  typedef struct packed {
    logic       valid;
    fsfp_word_t word;
  } fsfp_head_t;

endpackage

`default_nettype wire

[rtl/fsfp_front.sv]
// Front stage: classifies each received byte against the start and end flags.
// Depends on fsfp_pkg.
`default_nettype none

module fsfp_front (
  input  wire logic [fsfp_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [fsfp_pkg::BYTE_W-1:0] open_flag,
  input  wire logic [fsfp_pkg::BYTE_W-1:0] close_flag,
  output fsfp_pkg::fsfp_word_t             word
);

  // end flag wins over start flag
  always_comb begin
    word.rx_byte  = rx_byte;
    word.is_end   = (rx_byte == close_flag);
    word.is_start = (rx_byte == open_flag) && (rx_byte != close_flag);
  end

endmodule

`default_nettype wire

[rtl/fsfp_queue.sv]
// Short word queue between the classifying front and the parsing back.
// Depends on fsfp_pkg.
`default_nettype none

module fsfp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire fsfp_pkg::fsfp_word_t push_word,
  output logic                      full,
  input  wire logic                 pop,
  output fsfp_pkg::fsfp_head_t      head
);

  fsfp_pkg::fsfp_word_t mem_r [fsfp_pkg::QUEUE_DEPTH];

  logic [fsfp_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fsfp_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fsfp_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full    = (count_r == (fsfp_pkg::QUEUE_AW+1)'(fsfp_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

[rtl/fsfp_back.sv]
// Back stage: packet phase tracking, field capture and the result register.
// Depends on fsfp_pkg.
`default_nettype none

module fsfp_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [fsfp_pkg::BYTE_W-1:0]   servo_command,
  input  wire fsfp_pkg::fsfp_head_t          head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fsfp_pkg::POS_W-1:0]         out_servo_position
);

  logic [1:0]                       phase_r, phase_nxt;
  logic [fsfp_pkg::BYTE_W-1:0]      cmd_r, cmd_nxt;
  logic [fsfp_pkg::BYTE_W-1:0]      item_r, item_nxt;
  logic [fsfp_pkg::BYTE_W-1:0]      first_r, first_nxt;
  logic [fsfp_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [fsfp_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [fsfp_pkg::COUNT_W:0]       count_inc;
  logic                             emit, out_free;

  assign emit      = head.word.is_end && (cmd_r == servo_command);
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = head.valid && (!emit || out_free);
  assign count_inc = {1'b0, count_r} + 1'b1;

  assign out_valid          = out_valid_r;
  assign out_servo_position = pos_r;

  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    item_nxt      = item_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      if (head.word.is_end) begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = {first_r, item_r};
        end
        cmd_nxt   = '0;
        item_nxt  = '0;
        phase_nxt = fsfp_pkg::PH_START;
      end else begin
        unique case (phase_r)
          fsfp_pkg::PH_START: begin
            if (head.word.is_start) begin
              first_nxt = '0;
              count_nxt = '0;
              phase_nxt = fsfp_pkg::PH_CMD;
            end
          end
          fsfp_pkg::PH_CMD: begin
            cmd_nxt   = head.word.rx_byte;
            phase_nxt = fsfp_pkg::PH_ITEM;
          end
          fsfp_pkg::PH_ITEM: begin
            item_nxt  = head.word.rx_byte;
            phase_nxt = fsfp_pkg::PH_DATA;
          end
          fsfp_pkg::PH_DATA: begin
            if (count_r == '0) begin
              first_nxt = head.word.rx_byte;
            end
            count_nxt = (count_inc > {1'b0, fsfp_pkg::COUNT_SAT}) ?
                        fsfp_pkg::COUNT_SAT : count_inc[fsfp_pkg::COUNT_W-1:0];
            if (count_inc > fsfp_pkg::MAX_DATA) begin
              phase_nxt = fsfp_pkg::PH_START;
            end
          end
          default: phase_nxt = fsfp_pkg::PH_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fsfp_pkg::PH_START;
      cmd_r       <= '0;
      item_r      <= '0;
      first_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      item_r      <= item_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

endmodule

`default_nettype wire

[rtl/flag_framed_servo_command_parser_core.sv]
// Top level of the flag framed servo command parser: configuration registers,
// front classifier, word queue and parsing back stage. Depends on fsfp_pkg.
//
// Takes one received byte per cycle while in_stall is low and frames packets of start
// flag, command, item and data bytes closed by the end flag. A servo position (first
// data byte high, item byte low) appears on the output once the end flag word has
// passed the word queue and the result register; the back stage updates its phase
// once per cycle while not stalled, so the rate is one word per cycle. A waiting result
// stalls the back stage only when the next word would produce another result; the
// two-word queue then fills and in_stall rises. Write configuration only while idle.
`default_nettype none

module flag_framed_servo_command_parser_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fsfp_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fsfp_pkg::POS_W-1:0]           out_servo_position,
  input  wire logic                            cfg_we,
  input  wire logic [fsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fsfp_pkg::BYTE_W-1:0]     cfg_wdata
);

  logic [fsfp_pkg::BYTE_W-1:0] open_flag_r, close_flag_r, servo_cmd_r;
  fsfp_pkg::fsfp_word_t        front_word;
  fsfp_pkg::fsfp_head_t        head;
  logic                        q_full, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_flag_r  <= fsfp_pkg::START_FLAG_RST;
      close_flag_r <= fsfp_pkg::END_FLAG_RST;
      servo_cmd_r  <= fsfp_pkg::SERVO_COMMAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsfp_pkg::REG_START_FLAG:    open_flag_r  <= cfg_wdata;
        fsfp_pkg::REG_END_FLAG:      close_flag_r <= cfg_wdata;
        fsfp_pkg::REG_SERVO_COMMAND: servo_cmd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  fsfp_front u_front (
    .rx_byte    (in_rx_byte),
    .open_flag  (open_flag_r),
    .close_flag (close_flag_r),
    .word       (front_word)
  );

  fsfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head)
  );

  fsfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .servo_command      (servo_cmd_r),
    .head               (head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_servo_position (out_servo_position)
  );

endmodule

`default_nettype wire

[rtl/fsfp_checker.sv]
// Port-level checks for the flag framed servo command parser, bound to the top.
// Depends on fsfp_pkg.
`default_nettype none

module fsfp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [fsfp_pkg::POS_W-1:0]    out_servo_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_servo_position))
    else $error("stalled result word dropped or changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word waiting");

endmodule

bind flag_framed_servo_command_parser_core fsfp_checker u_fsfp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_servo_position (out_servo_position)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for flag_framed_servo_command_parser_core: drives received bytes and
// flag settings, predicts servo positions and checks every output word in order.
// Depends on fsfp_pkg and the core RTL only.

module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  class servo_frame_tracker;
    logic [fsfp_pkg::BYTE_W-1:0]  open_flag;
    logic [fsfp_pkg::BYTE_W-1:0]  close_flag;
    logic [fsfp_pkg::BYTE_W-1:0]  servo_cmd;
    logic [1:0]                   phase;
    logic [fsfp_pkg::BYTE_W-1:0]  command;
    logic [fsfp_pkg::BYTE_W-1:0]  item;
    logic [fsfp_pkg::BYTE_W-1:0]  first_data;
    logic [fsfp_pkg::COUNT_W-1:0] data_count;
    logic [fsfp_pkg::POS_W-1:0]   pending_positions[$];
    int                           mismatch_count;

    function new();
      open_flag = fsfp_pkg::START_FLAG_RST;
      close_flag = fsfp_pkg::END_FLAG_RST;
      servo_cmd = fsfp_pkg::SERVO_COMMAND_RST;
      phase = fsfp_pkg::PH_START;
      command = '0;
      item = '0;
      first_data = '0;
      data_count = '0;
      mismatch_count = 0;
    endfunction

    function void set_flags(logic [fsfp_pkg::BYTE_W-1:0] s, logic [fsfp_pkg::BYTE_W-1:0] e,
                            logic [fsfp_pkg::BYTE_W-1:0] c);
      open_flag = s;
      close_flag = e;
      servo_cmd = c;
    endfunction

    function int pending();
      return pending_positions.size();
    endfunction

    function void note_rx_byte(logic [fsfp_pkg::BYTE_W-1:0] b);
      logic [fsfp_pkg::COUNT_W:0] next_count;
      if (b == close_flag) begin
        if (command == servo_cmd) pending_positions.push_back({first_data, item});
        command = '0;
        item = '0;
        phase = fsfp_pkg::PH_START;
      end else begin
        case (phase)
          fsfp_pkg::PH_START: begin
            if (b == open_flag) begin
              first_data = '0;
              data_count = '0;
              phase = fsfp_pkg::PH_CMD;
            end
          end
          fsfp_pkg::PH_CMD: begin
            command = b;
            phase = fsfp_pkg::PH_ITEM;
          end
          fsfp_pkg::PH_ITEM: begin
            item = b;
            phase = fsfp_pkg::PH_DATA;
          end
          default: begin
            next_count = {1'b0, data_count} + 1'b1;
            if (data_count == '0) first_data = b;
            data_count = (next_count > {1'b0, fsfp_pkg::COUNT_SAT}) ? fsfp_pkg::COUNT_SAT
                                                    : next_count[fsfp_pkg::COUNT_W-1:0];
            if (next_count > fsfp_pkg::MAX_DATA) phase = fsfp_pkg::PH_START;
          end
        endcase
      end
    endfunction

    function void check_position(logic [fsfp_pkg::POS_W-1:0] got);
      logic [fsfp_pkg::POS_W-1:0] want;
      if (pending_positions.size() == 0) begin
        $display("%0t: servo position expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_positions.pop_front();
        if (got !== want) begin
          $display("%0t: servo position expected %h, actual %h", $time, want, got);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [fsfp_pkg::BYTE_W-1:0]    in_rx_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [fsfp_pkg::POS_W-1:0]     out_servo_position;
  logic                           cfg_we;
  logic [fsfp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fsfp_pkg::BYTE_W-1:0]    cfg_wdata;

  servo_frame_tracker tracker;
  bit sender_eager;
  bit receiver_eager;
  bit long_hold_req;
  int bytes_sent;

  flag_framed_servo_command_parser_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_servo_position(out_servo_position),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait(bit eager);
    if (eager || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [fsfp_pkg::BYTE_W-1:0] any_byte();
    return fsfp_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [fsfp_pkg::BYTE_W-1:0] b);
    int gap;
    gap = draw_wait(sender_eager);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_flags(input logic [fsfp_pkg::BYTE_W-1:0] s,
                               input logic [fsfp_pkg::BYTE_W-1:0] e,
                               input logic [fsfp_pkg::BYTE_W-1:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= fsfp_pkg::REG_START_FLAG;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= fsfp_pkg::REG_END_FLAG;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= fsfp_pkg::REG_SERVO_COMMAND;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_flags(s, e, c);
  endtask

  task automatic send_random_packet();
    int kind;
    int n;
    logic [fsfp_pkg::BYTE_W-1:0] cmd;
    kind = $urandom_range(0, 9);
    sender_eager = ($urandom_range(0, 3) == 0);
    if (kind == 0) begin
      send_byte(any_byte());
    end else begin
      cmd = ($urandom_range(0, 3) != 0) ? tracker.servo_cmd : any_byte();
      send_byte(tracker.open_flag);
      if (kind == 1) begin
        n = $urandom_range(0, 2);
        repeat (n) send_byte(any_byte());
        send_byte(tracker.close_flag);
      end else begin
        send_byte(cmd);
        send_byte(any_byte());
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
        repeat (n) send_byte(any_byte());
        if ($urandom_range(0, 7) != 0) send_byte(tracker.close_flag);
      end
    end
  endtask

  task automatic run_packets(input int count);
    int first;
    first = bytes_sent;
    receiver_eager = ($urandom_range(0, 2) == 0);
    while (bytes_sent - first < count) send_random_packet();
  endtask

  task automatic send_servo_burst();
    sender_eager = 1'b1;
    long_hold_req = 1'b1;
    repeat (6) begin
      send_byte(tracker.open_flag);
      send_byte(tracker.servo_cmd);
      send_byte(any_byte());
      send_byte(any_byte());
      send_byte(tracker.close_flag);
    end
  endtask

  // receiver: hold off for a drawn number of cycles before each word, or for LONG_HOLD on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      out_stall <= (hold > 0);
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_position(out_servo_position);
        hold = draw_wait(receiver_eager);
      end else if (hold > 0) begin
        hold--;
      end
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    sender_eager = 1'b0;
    receiver_eager = 1'b0;
    long_hold_req = 1'b0;
    bytes_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= fsfp_pkg::REG_START_FLAG;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end flag with no packet, stray byte, full-scale position, end in command phase
    send_byte(tracker.close_flag);
    send_byte(8'hAA);
    send_byte(tracker.open_flag);
    send_byte(tracker.servo_cmd);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(tracker.close_flag);
    send_byte(tracker.open_flag);
    send_byte(tracker.close_flag);
    // overflow the data count, then close with the kept command
    send_byte(tracker.open_flag);
    send_byte(tracker.servo_cmd);
    send_byte(8'h00);
    send_byte(8'h00);
    repeat (fsfp_pkg::MAX_DATA) send_byte(any_byte());
    send_byte(tracker.close_flag);

    run_packets(80);
    program_flags(8'h00, 8'hFF, 8'h00);
    receiver_eager = 1'b1;
    sender_eager = 1'b1;
    repeat (20) send_byte(any_byte());
    run_packets(80);
    program_flags(8'hFF, 8'h00, 8'hFF);
    run_packets(100);
    program_flags(8'h7E, 8'h7E, any_byte());
    run_packets(80);
    program_flags(any_byte(), any_byte(), any_byte());
    run_packets(50);
    send_servo_burst();
    run_packets(50);
    program_flags(fsfp_pkg::START_FLAG_RST, fsfp_pkg::END_FLAG_RST,
                  fsfp_pkg::SERVO_COMMAND_RST);
    run_packets(100);

    drain();
    if (tracker.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
